// File: hdl/awad_pkg.sv
// Shared types and constants for the alpha weighted area downscale core.
// No dependencies; every other file of the block imports this package.
package awad_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int CFG_W   = 13;   // width of every configuration register
   localparam int CSR_IW  = 8;    // width of the register index
   localparam int PIX_W   = 8;    // width of one colour channel
   localparam int RS_W    = 40;   // weighted colour sum width
   localparam int AS_W    = 32;   // alpha sum width
   localparam int CNT_W   = 25;   // pixel count width
   localparam int DIV_W   = RS_W; // operand width of the shared dividers

   localparam logic [CSR_IW-1:0] REG_SRC_W = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] REG_SRC_H = CSR_IW'(1);
   localparam logic [CSR_IW-1:0] REG_TGT_W = CSR_IW'(2);
   localparam logic [CSR_IW-1:0] REG_TGT_H = CSR_IW'(3);

   // One row store entry: the running sums of one target column.
   typedef struct packed {
      logic [RS_W-1:0]  red;
      logic [RS_W-1:0]  green;
      logic [RS_W-1:0]  blue;
      logic [AS_W-1:0]  alpha;
      logic [CNT_W-1:0] count;
   } entry_type;

endpackage

// File: hdl/awad_div.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on awad_pkg for the default operand width.
module awad_div #(
   parameter int W = awad_pkg::DIV_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);
   import awad_pkg::*;

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W:0]    shifted;
   logic          fits;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? W'(shifted - {1'b0, den_ff}) : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// File: hdl/awad_store.sv
// Row store: one entry of running sums per target column, one write port
// and one read port with registered read data. Depends on awad_pkg.
module awad_store #(
   parameter int DEPTH = awad_pkg::DEF_MAX_WIDTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  awad_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output awad_pkg::entry_type rd_data
);
   import awad_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;
endmodule

// File: hdl/alpha_weighted_area_downscale_core.sv
// Alpha weighted area downscale core: the row store, the dividers and the
// sequencer that walks the source frame. Depends on awad_pkg, awad_div and
// awad_store.
//
// Source RGBA pixels enter in raster order on the req_ stream, one request
// per pixel. Each target pixel averages a source rectangle; its sums live
// in a row store with one entry per target column. When the last source
// pixel of a rectangle arrives, one averaged pixel leaves on the rsp_ stream,
// with tlast marking the last target pixel of the frame.
// The csr_ channel writes the four size registers; a write to any of them
// restarts the frame position and recomputes the window boundaries.
// Timing: one request at a time. A pixel passes through accept, store
// read-modify-write and position update. When it closes a column window the
// next column and row edges are computed by the red and green serial dividers
// after a multiply step. When it closes a rectangle, a divider start, the four
// parallel dividers and a load of the output register come first. The serial
// dividers are 40 bits wide. A size write recomputes the window edges in the
// same way before the next request is taken.
// Reset clears the sizes to 1 and the position to the frame start; the row
// store is not cleared, since every entry is written at the first row of its
// band. A stalled receiver holds the result in the output register; the
// next request is still accepted and processed until a new result is ready.
module alpha_weighted_area_downscale_core #(
   parameter int MAX_WIDTH  = awad_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = awad_pkg::DEF_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata: red_in, green_in, blue_in, alpha_in from bit 0 up
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,
   // rsp_tdata: red_out, green_out, blue_out, alpha_out from bit 0 up
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,
   output logic                       rsp_tlast,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [awad_pkg::CSR_IW-1:0] csr_index,
   input  logic [awad_pkg::CFG_W-1:0]  csr_data
);
   import awad_pkg::*;

   localparam int XW  = $clog2(MAX_WIDTH + 1);
   localparam int YW  = $clog2(MAX_HEIGHT + 1);
   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int AYW = $clog2(MAX_HEIGHT);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ACC  = 4'd1;
   localparam logic [3:0] S_DGO  = 4'd2;
   localparam logic [3:0] S_DIV  = 4'd3;
   localparam logic [3:0] S_OUT  = 4'd4;
   localparam logic [3:0] S_ADV  = 4'd5;
   localparam logic [3:0] S_BMUL = 4'd6;
   localparam logic [3:0] S_BGO  = 4'd7;
   localparam logic [3:0] S_BDIV = 4'd8;

   logic [3:0] state_ff, state_in;

   // Configuration registers.
   logic [CFG_W-1:0] src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [CFG_W-1:0] tgt_w_ff, tgt_w_in, tgt_h_ff, tgt_h_in;
   logic [XW-1:0]    sw_eff, tw_eff;
   logic [YW-1:0]    sh_eff, th_eff;

   // Frame position.
   logic [AW-1:0]  src_col_ff, src_col_in, tc_ff, tc_in;
   logic [AYW-1:0] src_row_ff, src_row_in, tr_ff, tr_in;
   logic [XW-1:0]  col_bnd_ff, col_bnd_in, col_start_ff, col_start_in;
   logic [YW-1:0]  row_bnd_ff, row_bnd_in, row_start_ff, row_start_in;
   logic [2*XW-1:0] col_num_ff;
   logic [2*YW-1:0] row_num_ff;

   // Pixel and sums in flight.
   logic [PIX_W-1:0] red_ff, green_ff, blue_ff, alpha_ff;
   entry_type        rd_entry, new_entry, sum_ff;
   logic             emit_ff, emit_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic req_fire, csr_fire, div_start, div_done;
   logic [DIV_W-1:0] num_r, den_r, num_g, den_g, quo_r, quo_g, quo_b, quo_a;
   logic done_g, done_b, done_a;

   logic [XW-1:0] col_next, tc_next;
   logic [YW-1:0] row_next, tr_next;
   logic          first_px;
   logic [2*PIX_W-1:0] ra, ga, ba;

   // Effective sizes after clamping.
   always_comb begin
      if (src_w_ff == '0)                   sw_eff = XW'(1);
      else if (32'(src_w_ff) > MAX_WIDTH)   sw_eff = XW'(MAX_WIDTH);
      else                                  sw_eff = XW'(src_w_ff);
      if (src_h_ff == '0)                   sh_eff = YW'(1);
      else if (32'(src_h_ff) > MAX_HEIGHT)  sh_eff = YW'(MAX_HEIGHT);
      else                                  sh_eff = YW'(src_h_ff);
      if (tgt_w_ff == '0)                   tw_eff = XW'(1);
      else if (32'(tgt_w_ff) > 32'(sw_eff)) tw_eff = sw_eff;
      else                                  tw_eff = XW'(tgt_w_ff);
      if (tgt_h_ff == '0)                   th_eff = YW'(1);
      else if (32'(tgt_h_ff) > 32'(sh_eff)) th_eff = sh_eff;
      else                                  th_eff = YW'(tgt_h_ff);
   end

   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;

   // Read-modify-write of the row store entry of the current target column.
   assign first_px = (XW'(src_col_ff) == col_start_ff) && (YW'(src_row_ff) == row_start_ff);
   assign ra = red_ff * alpha_ff;
   assign ga = green_ff * alpha_ff;
   assign ba = blue_ff * alpha_ff;

   always_comb begin
      if (first_px) begin
         new_entry.red   = RS_W'(ra);
         new_entry.green = RS_W'(ga);
         new_entry.blue  = RS_W'(ba);
         new_entry.alpha = AS_W'(alpha_ff);
         new_entry.count = CNT_W'(1);
      end else begin
         new_entry.red   = rd_entry.red + RS_W'(ra);
         new_entry.green = rd_entry.green + RS_W'(ga);
         new_entry.blue  = rd_entry.blue + RS_W'(ba);
         new_entry.alpha = rd_entry.alpha + AS_W'(alpha_ff);
         new_entry.count = rd_entry.count + CNT_W'(1);
      end
   end

   awad_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (state_ff == S_ACC),
      .wr_addr (tc_ff),
      .wr_data (new_entry),
      .rd_en   (req_fire),
      .rd_addr (tc_ff),
      .rd_data (rd_entry)
   );

   // The red and green dividers also compute the window edges.
   assign div_start = (state_ff == S_DGO) || (state_ff == S_BGO);
   assign num_r = (state_ff == S_BGO) ? DIV_W'(col_num_ff) : sum_ff.red;
   assign den_r = (state_ff == S_BGO) ? DIV_W'(tw_eff)     : DIV_W'(sum_ff.alpha);
   assign num_g = (state_ff == S_BGO) ? DIV_W'(row_num_ff) : sum_ff.green;
   assign den_g = (state_ff == S_BGO) ? DIV_W'(th_eff)     : DIV_W'(sum_ff.alpha);

   awad_div #(.W(DIV_W)) u_div_r (
      .clock(clock), .reset(reset), .start(div_start), .dividend(num_r),
      .divisor(den_r), .done(div_done), .quotient(quo_r));
   awad_div #(.W(DIV_W)) u_div_g (
      .clock(clock), .reset(reset), .start(div_start), .dividend(num_g),
      .divisor(den_g), .done(done_g), .quotient(quo_g));
   awad_div #(.W(DIV_W)) u_div_b (
      .clock(clock), .reset(reset), .start(div_start), .dividend(sum_ff.blue),
      .divisor(DIV_W'(sum_ff.alpha)), .done(done_b), .quotient(quo_b));
   awad_div #(.W(DIV_W)) u_div_a (
      .clock(clock), .reset(reset), .start(div_start), .dividend(DIV_W'(sum_ff.alpha)),
      .divisor(DIV_W'(sum_ff.count)), .done(done_a), .quotient(quo_a));

   assign col_next = XW'(src_col_ff) + XW'(1);
   assign tc_next  = XW'(tc_ff) + XW'(1);
   assign row_next = YW'(src_row_ff) + YW'(1);
   assign tr_next  = YW'(tr_ff) + YW'(1);
   assign emit_in  = (row_next == row_bnd_ff) && (col_next == col_bnd_ff);

   always_comb begin
      state_in     = state_ff;
      src_w_in     = src_w_ff;
      src_h_in     = src_h_ff;
      tgt_w_in     = tgt_w_ff;
      tgt_h_in     = tgt_h_ff;
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      tc_in        = tc_ff;
      tr_in        = tr_ff;
      col_bnd_in   = col_bnd_ff;
      row_bnd_in   = row_bnd_ff;
      col_start_in = col_start_ff;
      row_start_in = row_start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_fire) begin
               unique case (csr_index)
                  REG_SRC_W: src_w_in = csr_data;
                  REG_SRC_H: src_h_in = csr_data;
                  REG_TGT_W: tgt_w_in = csr_data;
                  REG_TGT_H: tgt_h_in = csr_data;
                  default: ;
               endcase
               if (csr_index == REG_SRC_W || csr_index == REG_SRC_H ||
                   csr_index == REG_TGT_W || csr_index == REG_TGT_H) begin
                  src_col_in   = '0;
                  src_row_in   = '0;
                  tc_in        = '0;
                  tr_in        = '0;
                  col_start_in = '0;
                  row_start_in = '0;
                  state_in     = S_BMUL;
               end
            end else if (req_fire) begin
               state_in = S_ACC;
            end
         end
         S_ACC:  state_in = emit_ff ? S_DGO : S_ADV;
         S_DGO:  state_in = S_DIV;
         S_DIV:  if (div_done) state_in = S_OUT;
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in[7:0]    = (sum_ff.alpha == '0) ? '0 : quo_r[7:0];
               rsp_data_in[15:8]   = (sum_ff.alpha == '0) ? '0 : quo_g[7:0];
               rsp_data_in[23:16]  = (sum_ff.alpha == '0) ? '0 : quo_b[7:0];
               rsp_data_in[31:24]  = (sum_ff.count == '0) ? '0 : quo_a[7:0];
               rsp_last_in         = (tc_next == tw_eff) && (tr_next == th_eff);
               state_in            = S_ADV;
            end
         end
         S_ADV: begin
            if (col_next >= col_bnd_ff) begin
               state_in = S_BMUL;
               if (tc_next >= tw_eff) begin
                  tc_in        = '0;
                  src_col_in   = '0;
                  col_start_in = '0;
                  src_row_in   = AYW'(row_next);
                  if (row_next >= row_bnd_ff) begin
                     if (tr_next >= th_eff) begin
                        tr_in        = '0;
                        src_row_in   = '0;
                        row_start_in = '0;
                     end else begin
                        tr_in        = AYW'(tr_next);
                        row_start_in = row_bnd_ff;
                     end
                  end
               end else begin
                  tc_in        = AW'(tc_next);
                  src_col_in   = AW'(col_next);
                  col_start_in = col_bnd_ff;
               end
            end else begin
               src_col_in = AW'(col_next);
               state_in   = S_IDLE;
            end
         end
         S_BMUL: state_in = S_BGO;
         S_BGO:  state_in = S_BDIV;
         S_BDIV: begin
            if (div_done) begin
               col_bnd_in = XW'(quo_r);
               row_bnd_in = YW'(quo_g);
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         src_w_ff     <= CFG_W'(1);
         src_h_ff     <= CFG_W'(1);
         tgt_w_ff     <= CFG_W'(1);
         tgt_h_ff     <= CFG_W'(1);
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         tc_ff        <= '0;
         tr_ff        <= '0;
         col_bnd_ff   <= XW'(1);
         row_bnd_ff   <= YW'(1);
         col_start_ff <= '0;
         row_start_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_w_ff     <= src_w_in;
         src_h_ff     <= src_h_in;
         tgt_w_ff     <= tgt_w_in;
         tgt_h_ff     <= tgt_h_in;
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         tc_ff        <= tc_in;
         tr_ff        <= tr_in;
         col_bnd_ff   <= col_bnd_in;
         row_bnd_ff   <= row_bnd_in;
         col_start_ff <= col_start_in;
         row_start_ff <= row_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (req_fire) begin
         red_ff   <= req_tdata[7:0];
         green_ff <= req_tdata[15:8];
         blue_ff  <= req_tdata[23:16];
         alpha_ff <= req_tdata[31:24];
         emit_ff  <= emit_in;
      end
      if (state_ff == S_ACC) begin
         sum_ff <= new_entry;
      end
      if (state_ff == S_BMUL) begin
         col_num_ff <= (XW'(tc_ff) + XW'(1)) * sw_eff;
         row_num_ff <= (YW'(tr_ff) + YW'(1)) * sh_eff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

// File: hdl/awad_checker.sv
// Port-level checks for the alpha weighted area downscale core, bound to
// the top level. Depends on awad_pkg for the configuration port widths.
module awad_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [31:0]                 rsp_tdata,
   input logic                        rsp_tlast,
   input logic                        csr_valid,
   input logic                        csr_ready,
   input logic [awad_pkg::CSR_IW-1:0] csr_index
);
   import awad_pkg::*;

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Reset leaves no result pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // One pixel is worked on at a time.
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !csr_ready)
      else $error("request taken while one is in work");

   // A write to the source width or target height register recomputes the window edges before the next pixel.
   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == REG_SRC_W || csr_index == REG_TGT_H)
      |=> !req_tready)
      else $error("request taken during edge recompute");
endmodule

bind alpha_weighted_area_downscale_core awad_checker u_awad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index)
);
